// ===== rtl/bgc_pkg.sv =====
// Shared types, codes and helpers for the button gesture classifier.
package bgc_pkg;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned ACT_W    = 3;
    localparam int unsigned ARM_W    = 31;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned STATE_W  = 3;

    // gesture states
    localparam logic [STATE_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [STATE_W-1:0] ST_DOWN1 = 3'd1;
    localparam logic [STATE_W-1:0] ST_WAIT2 = 3'd2;
    localparam logic [STATE_W-1:0] ST_DOWN2 = 3'd3;
    localparam logic [STATE_W-1:0] ST_HELD  = 3'd4;

    // event kinds
    localparam logic [CMD_W-1:0] EV_DOWN  = 2'd0;
    localparam logic [CMD_W-1:0] EV_UP    = 2'd1;
    localparam logic [CMD_W-1:0] EV_TIMER = 2'd2;

    // actions
    localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_MARKER  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PAIRING = 3'd2;
    localparam logic [ACT_W-1:0] ACT_OFF     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REBOOT  = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REBOOT_PRESS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 2'd3;

    // register reset values
    localparam logic [CFG_W-1:0] RST_DOUBLE_WINDOW = 16'd450;
    localparam logic [CFG_W-1:0] RST_LONG_PRESS    = 16'd1500;
    localparam logic [CFG_W-1:0] RST_REBOOT_PRESS  = 16'd10000;
    localparam logic [CFG_W-1:0] RST_DEBOUNCE      = 16'd30;

    typedef struct packed {
        logic [CFG_W-1:0] double_window_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] reboot_press_ms;
        logic [CFG_W-1:0] debounce_ms;
    } t_cfg;

    // Time left to a deadline with wraparound; past or zero clamps to 1.
    function automatic logic [ARM_W-1:0] time_left(input logic [TIME_W-1:0] deadline,
                                                   input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] rem;
        rem = deadline - now;
        if (rem == '0 || rem[TIME_W-1]) begin
            return ARM_W'(1);
        end
        return rem[ARM_W-1:0];
    endfunction

endpackage

// ===== rtl/bgc_req_if.sv =====
// Request channel: one button event per request.
interface bgc_req_if;
    import bgc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] event_time_ms;

    modport source (output valid, output cmd, output event_time_ms, input ready);
    modport sink   (input valid, input cmd, input event_time_ms, output ready);
endinterface

// ===== rtl/bgc_res_if.sv =====
// Result channel: action and timer to arm.
interface bgc_res_if;
    import bgc_pkg::*;

    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [ARM_W-1:0] rearm_ms;

    modport source (output valid, output action, output rearm_ms, input ready);
    modport sink   (input valid, input action, input rearm_ms, output ready);
endinterface

// ===== rtl/button_gesture_classifier.sv =====
// A request waits in the request register and is classified as it moves into the result register.
// Throughput: one request per cycle while o_res.ready is high; a request register ahead of
// the classifier and a result register behind it, so a new request is taken while a result waits.
// Reset (synchronous, active low): idle, no timer pending, stored times zero,
// registers back to 450 / 1500 / 10000 / 30 ms, both stage registers empty.
module button_gesture_classifier (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bgc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bgc_pkg::CFG_W-1:0]       i_cfg_data,
    bgc_req_if.sink                         i_req,
    bgc_res_if.source                       o_res
);
    import bgc_pkg::*;

    // configuration registers
    t_cfg r_cfg;

    // request stage
    logic              r_in_valid;
    logic [CMD_W-1:0]  r_cmd;
    logic [TIME_W-1:0] r_time;

    // result stage
    logic              r_out_valid;
    logic [ACT_W-1:0]  r_action;
    logic [ARM_W-1:0]  r_arm;

    logic              w_req_take;
    logic              w_adv;
    logic [ACT_W-1:0]  w_action;
    logic [ARM_W-1:0]  w_arm;

    // request moves into the classifier when the result slot is free or draining
    assign w_adv       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || w_adv;
    assign w_req_take  = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.double_window_ms <= RST_DOUBLE_WINDOW;
            r_cfg.long_press_ms    <= RST_LONG_PRESS;
            r_cfg.reboot_press_ms  <= RST_REBOOT_PRESS;
            r_cfg.debounce_ms      <= RST_DEBOUNCE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DOUBLE_WINDOW: r_cfg.double_window_ms <= i_cfg_data;
                REG_LONG_PRESS:    r_cfg.long_press_ms    <= i_cfg_data;
                REG_REBOOT_PRESS:  r_cfg.reboot_press_ms  <= i_cfg_data;
                REG_DEBOUNCE:      r_cfg.debounce_ms      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_req_take || (r_in_valid && !w_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_req_take) begin
            r_cmd  <= i_req.cmd;
            r_time <= i_req.event_time_ms;
        end
    end

    // classifier updates its state only as a request leaves the request stage
    bgc_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_cmd    (r_cmd),
        .i_now    (r_time),
        .i_cfg    (r_cfg),
        .o_action (w_action),
        .o_arm    (w_arm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_action <= w_action;
            r_arm    <= w_arm;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.action   = r_action;
    assign o_res.rearm_ms = r_arm;

`ifndef NO_ASSERTIONS
    a_final_cancels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_action == ACT_OFF || r_action == ACT_REBOOT
                         || r_action == ACT_PAIRING)) |-> (r_arm == '0))
        else $error("terminal action left a timer armed");

    a_req_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_cmd) && $stable(r_time)))
        else $error("held request lost or overwritten");

    a_res_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> (r_out_valid && $stable(r_action)
                                             && $stable(r_arm)))
        else $error("stalled result lost or overwritten");
`endif

endmodule

// ===== rtl/bgc_fsm.sv =====
// Gesture state machine: holds gesture state and timer deadline, classifies one event.
module bgc_fsm (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [bgc_pkg::CMD_W-1:0]     i_cmd,
    input  logic [bgc_pkg::TIME_W-1:0]    i_now,
    input  bgc_pkg::t_cfg                 i_cfg,
    output logic [bgc_pkg::ACT_W-1:0]     o_action,
    output logic [bgc_pkg::ARM_W-1:0]     o_arm
);
    import bgc_pkg::*;

    logic [STATE_W-1:0] r_state, n_state;
    logic               r_pending, n_pending;
    logic [TIME_W-1:0]  r_press, n_press;
    logic [TIME_W-1:0]  r_first, n_first;
    logic [TIME_W-1:0]  r_deadline, n_deadline;

    logic [TIME_W-1:0]  w_held;
    logic [TIME_W-1:0]  w_since_rel;
    logic               w_ghost;
    logic               w_long;
    logic               w_late;

    assign w_held      = i_now - r_press;
    assign w_since_rel = i_now - r_first;
    assign w_ghost     = w_held < TIME_W'(i_cfg.debounce_ms);
    assign w_long      = w_held >= TIME_W'(i_cfg.long_press_ms);
    assign w_late      = w_since_rel >= TIME_W'(i_cfg.double_window_ms);

    always_comb begin
        n_state    = r_state;
        n_pending  = r_pending;
        n_press    = r_press;
        n_first    = r_first;
        n_deadline = r_deadline;
        o_action   = ACT_NONE;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd == EV_DOWN) begin
                    n_press    = i_now;
                    n_state    = ST_DOWN1;
                    n_deadline = i_now + TIME_W'(i_cfg.long_press_ms);
                    n_pending  = 1'b1;
                end else begin
                    n_pending = 1'b0;
                end
            end
            ST_DOWN1: begin
                if (i_cmd == EV_UP) begin
                    if (w_ghost) begin
                        n_state   = ST_IDLE;
                        n_pending = 1'b0;
                    end else if (w_long) begin
                        n_state   = ST_IDLE;
                        n_pending = 1'b0;
                        o_action  = ACT_OFF;
                    end else begin
                        n_first    = i_now;
                        n_state    = ST_WAIT2;
                        n_deadline = i_now + TIME_W'(i_cfg.double_window_ms);
                        n_pending  = 1'b1;
                    end
                end else if (i_cmd == EV_TIMER) begin
                    n_state    = ST_HELD;
                    n_deadline = r_press + TIME_W'(i_cfg.reboot_press_ms);
                    n_pending  = 1'b1;
                end
            end
            ST_WAIT2: begin
                if (i_cmd == EV_DOWN) begin
                    // window already over: overdue marker, fresh first press
                    if (w_late) begin
                        n_state  = ST_DOWN1;
                        o_action = ACT_MARKER;
                    end else begin
                        n_state = ST_DOWN2;
                    end
                    n_press    = i_now;
                    n_deadline = i_now + TIME_W'(i_cfg.long_press_ms);
                    n_pending  = 1'b1;
                end else if (i_cmd == EV_TIMER) begin
                    n_state   = ST_IDLE;
                    n_pending = 1'b0;
                    o_action  = ACT_MARKER;
                end
            end
            ST_DOWN2: begin
                if (i_cmd == EV_UP) begin
                    if (w_ghost) begin
                        // back to waiting, window keeps its original end
                        n_state    = ST_WAIT2;
                        n_deadline = r_first + TIME_W'(i_cfg.double_window_ms);
                        n_pending  = 1'b1;
                    end else begin
                        n_state   = ST_IDLE;
                        n_pending = 1'b0;
                        o_action  = w_long ? ACT_OFF : ACT_PAIRING;
                    end
                end else if (i_cmd == EV_TIMER) begin
                    n_state    = ST_HELD;
                    n_deadline = r_press + TIME_W'(i_cfg.reboot_press_ms);
                    n_pending  = 1'b1;
                end
            end
            ST_HELD: begin
                if (i_cmd == EV_UP) begin
                    n_state   = ST_IDLE;
                    n_pending = 1'b0;
                    o_action  = ACT_OFF;
                end else if (i_cmd == EV_TIMER) begin
                    n_state   = ST_IDLE;
                    n_pending = 1'b0;
                    o_action  = ACT_REBOOT;
                end
            end
            default: begin
                n_state   = ST_IDLE;
                n_pending = 1'b0;
            end
        endcase
    end

    // ignored events re-emit the time left; cancel gives 0
    assign o_arm = n_pending ? time_left(n_deadline, i_now) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pending  <= 1'b0;
            r_press    <= '0;
            r_first    <= '0;
            r_deadline <= '0;
        end else if (i_step) begin
            r_state    <= n_state;
            r_pending  <= n_pending;
            r_press    <= n_press;
            r_first    <= n_first;
            r_deadline <= n_deadline;
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_no_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pending)
        else $error("timer pending while idle");

    a_down_starts_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_state == ST_IDLE && i_cmd == EV_DOWN)
        |=> (r_state == ST_DOWN1 && r_pending && r_press == $past(i_now)))
        else $error("down edge in idle did not start a press");
`endif

endmodule

// ===== tb/button_gesture_classifier_tb.sv =====
// Self-checking testbench for the button gesture classifier.
`timescale 1ns / 100ps

module button_gesture_classifier_tb;

    import bgc_pkg::*;

    // Tracks the gesture machine alongside the block and holds the outcomes still owed.
    class gesture_scoreboard;

        typedef struct packed {
            logic [ACT_W-1:0] action;
            logic [ARM_W-1:0] arm_ms;
        } t_outcome;

        t_outcome expected_outcomes[$];

        logic [CFG_W-1:0]   window_ms;
        logic [CFG_W-1:0]   long_ms;
        logic [CFG_W-1:0]   reboot_hold_ms;
        logic [CFG_W-1:0]   debounce_ms;

        logic [STATE_W-1:0] gesture;
        bit                 timer_armed;
        logic [TIME_W-1:0]  press_at;
        logic [TIME_W-1:0]  release_at;
        logic [TIME_W-1:0]  deadline_at;

        int unsigned        mismatches;
        int unsigned        results_seen;

        function new();
            window_ms      = RST_DOUBLE_WINDOW;
            long_ms        = RST_LONG_PRESS;
            reboot_hold_ms = RST_REBOOT_PRESS;
            debounce_ms    = RST_DEBOUNCE;
            gesture        = ST_IDLE;
            timer_armed    = 1'b0;
            press_at       = '0;
            release_at     = '0;
            deadline_at    = '0;
            mismatches     = 0;
            results_seen   = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_DOUBLE_WINDOW: window_ms      = value;
                REG_LONG_PRESS:    long_ms        = value;
                REG_REBOOT_PRESS:  reboot_hold_ms = value;
                REG_DEBOUNCE:      debounce_ms    = value;
                default: ;
            endcase
        endfunction

        // Distance to the stored deadline; zero or already past gives 1.
        function logic [ARM_W-1:0] ms_to_deadline(logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] gap;
            gap = deadline_at - now;
            if (gap == '0 || gap[TIME_W-1]) begin
                return ARM_W'(1);
            end
            return gap[ARM_W-1:0];
        endfunction

        function logic [ARM_W-1:0] arm_until(logic [TIME_W-1:0] now, logic [TIME_W-1:0] due);
            deadline_at = due;
            timer_armed = 1'b1;
            return ms_to_deadline(now);
        endfunction

        function logic [ARM_W-1:0] keep_timer(logic [TIME_W-1:0] now);
            return timer_armed ? ms_to_deadline(now) : '0;
        endfunction

        function logic [ARM_W-1:0] cancel_timer();
            timer_armed = 1'b0;
            return '0;
        endfunction

        // Classify one accepted event, queue its outcome and hand back the timer to arm.
        function logic [ARM_W-1:0] classify_event(logic [CMD_W-1:0] cmd,
                                                  logic [TIME_W-1:0] now);
            logic [ACT_W-1:0]  act;
            logic [ARM_W-1:0]  arm_ms;
            logic [TIME_W-1:0] held;
            t_outcome          entry;
            act  = ACT_NONE;
            held = now - press_at;
            case (gesture)
                ST_IDLE: begin
                    if (cmd == EV_DOWN) begin
                        press_at = now;
                        gesture  = ST_DOWN1;
                        arm_ms   = arm_until(now, now + TIME_W'(long_ms));
                    end else begin
                        arm_ms = cancel_timer();
                    end
                end
                ST_DOWN1: begin
                    if (cmd == EV_UP) begin
                        if (held < TIME_W'(debounce_ms)) begin
                            gesture = ST_IDLE;
                            arm_ms  = cancel_timer();
                        end else if (held >= TIME_W'(long_ms)) begin
                            gesture = ST_IDLE;
                            arm_ms  = cancel_timer();
                            act     = ACT_OFF;
                        end else begin
                            release_at = now;
                            gesture    = ST_WAIT2;
                            arm_ms     = arm_until(now, now + TIME_W'(window_ms));
                        end
                    end else if (cmd == EV_TIMER) begin
                        gesture = ST_HELD;
                        arm_ms  = arm_until(now, press_at + TIME_W'(reboot_hold_ms));
                    end else begin
                        arm_ms = keep_timer(now);
                    end
                end
                ST_WAIT2: begin
                    if (cmd == EV_DOWN) begin
                        if (now - release_at >= TIME_W'(window_ms)) begin
                            gesture = ST_DOWN1;
                            act     = ACT_MARKER;
                        end else begin
                            gesture = ST_DOWN2;
                        end
                        press_at = now;
                        arm_ms   = arm_until(now, now + TIME_W'(long_ms));
                    end else if (cmd == EV_TIMER) begin
                        gesture = ST_IDLE;
                        arm_ms  = cancel_timer();
                        act     = ACT_MARKER;
                    end else begin
                        arm_ms = keep_timer(now);
                    end
                end
                ST_DOWN2: begin
                    if (cmd == EV_UP) begin
                        if (held < TIME_W'(debounce_ms)) begin
                            gesture = ST_WAIT2;
                            arm_ms  = arm_until(now, release_at + TIME_W'(window_ms));
                        end else begin
                            gesture = ST_IDLE;
                            arm_ms  = cancel_timer();
                            act     = (held >= TIME_W'(long_ms)) ? ACT_OFF : ACT_PAIRING;
                        end
                    end else if (cmd == EV_TIMER) begin
                        gesture = ST_HELD;
                        arm_ms  = arm_until(now, press_at + TIME_W'(reboot_hold_ms));
                    end else begin
                        arm_ms = keep_timer(now);
                    end
                end
                ST_HELD: begin
                    if (cmd == EV_UP) begin
                        gesture = ST_IDLE;
                        arm_ms  = cancel_timer();
                        act     = ACT_OFF;
                    end else if (cmd == EV_TIMER) begin
                        gesture = ST_IDLE;
                        arm_ms  = cancel_timer();
                        act     = ACT_REBOOT;
                    end else begin
                        arm_ms = keep_timer(now);
                    end
                end
                default: begin
                    gesture = ST_IDLE;
                    arm_ms  = cancel_timer();
                end
            endcase
            entry.action = act;
            entry.arm_ms = arm_ms;
            expected_outcomes.push_back(entry);
            return arm_ms;
        endfunction

        task report(string msg);
            $display("[%0t] gesture mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_outcome(logic [ACT_W-1:0] action, logic [ARM_W-1:0] arm_ms);
            t_outcome want;
            results_seen++;
            if (expected_outcomes.size() == 0) begin
                report($sformatf("result %0d unexpected: action %0d arm %0d",
                                 results_seen, action, arm_ms));
                return;
            end
            want = expected_outcomes.pop_front();
            if (action !== want.action) begin
                report($sformatf("result %0d action %0d, expected %0d",
                                 results_seen, action, want.action));
            end
            if (arm_ms !== want.arm_ms) begin
                report($sformatf("result %0d arm %0d, expected %0d",
                                 results_seen, arm_ms, want.arm_ms));
            end
        endtask

    endclass

    // Event code three has no name in the package; the block treats it as a non-event.
    localparam logic [CMD_W-1:0] EV_SPARE = 2'd3;

    localparam int unsigned PHASES       = 6;
    localparam int unsigned PHASE_EVENTS = 85;
    localparam int unsigned HOLD_CYCLES  = 80;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    bgc_req_if req_ch ();
    bgc_res_if res_ch ();

    button_gesture_classifier dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    gesture_scoreboard tracker = new();

    // idle rates in percent for each side, changed per phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // set by the stimulus to ask the result side for one long stall
    bit          hold_results = 1'b0;
    int unsigned hold_left    = 0;

    // Button model for the random part: the next physical edge is planned ahead,
    // and the timer that the block asked for is fired when it falls due first.
    bit                button_pressed;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] edge_at;
    bit                timer_live;
    logic [TIME_W-1:0] timer_at;

    always #5 i_clk = ~i_clk;

    // Result side: check every accepted result against the oldest outstanding
    // outcome, then pick ready for the next edge. A requested stall is counted
    // here so the request side can keep pushing into the block meanwhile.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            tracker.check_outcome(res_ch.action, res_ch.rearm_ms);
        end
        if (hold_results && hold_left == 0) begin
            hold_left    = HOLD_CYCLES;
            hold_results = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offer one request and wait until the block takes it; the outcome is
    // predicted at the accepting edge. Valid stays high unless a gap is drawn.
    task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] stamp,
                              output logic [ARM_W-1:0] arm_ms);
        req_ch.valid         <= 1'b1;
        req_ch.cmd           <= cmd;
        req_ch.event_time_ms <= stamp;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        arm_ms = tracker.classify_event(cmd, stamp);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Stop offering and let every outstanding result drain before returning.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (tracker.expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        tracker.set_register(idx, value);
    endtask

    // Only called once the block has drained.
    task automatic apply_settings(input logic [CFG_W-1:0] window, input logic [CFG_W-1:0] long_hold,
                                  input logic [CFG_W-1:0] reboot, input logic [CFG_W-1:0] debounce);
        write_reg(REG_DOUBLE_WINDOW, window);
        write_reg(REG_LONG_PRESS,    long_hold);
        write_reg(REG_REBOOT_PRESS,  reboot);
        write_reg(REG_DEBOUNCE,      debounce);
        i_cfg_we <= 1'b0;
    endtask

    // Press length: ghost, ordinary, long hold, or at or past the reboot time.
    function automatic logic [TIME_W-1:0] hold_length();
        int unsigned roll;
        int unsigned db;
        int unsigned lp;
        int unsigned rb;
        roll = $urandom_range(0, 9);
        db   = 32'(tracker.debounce_ms);
        lp   = 32'(tracker.long_ms);
        rb   = 32'(tracker.reboot_hold_ms);
        if (roll < 2)      return $urandom_range(0, db);
        else if (roll < 6) return $urandom_range(db, lp);
        else if (roll < 8) return $urandom_range(lp, lp + rb);
        else               return $urandom_range(rb, rb + 3000);
    endfunction

    // Time between presses: inside the double window, just past it, or long idle.
    function automatic logic [TIME_W-1:0] gap_length();
        int unsigned roll;
        int unsigned dw;
        roll = $urandom_range(0, 9);
        dw   = 32'(tracker.window_ms);
        if (roll < 5)      return $urandom_range(0, dw);
        else if (roll < 8) return $urandom_range(dw, dw + 2000);
        else               return $urandom_range(0, 100000);
    endfunction

    // One random request: mostly the next step of a plausible button history,
    // sometimes a lost or late timer, and some noise with any code and time.
    task automatic gesture_step();
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] stamp;
        logic [ARM_W-1:0]  arm_ms;
        int unsigned       late;
        if ($urandom_range(0, 99) < 12) begin
            cmd = CMD_W'($urandom_range(0, 3));
            if ($urandom_range(0, 1) != 0) begin
                stamp = $urandom();
            end else begin
                stamp  = now_ms + $urandom_range(0, 2000);
                now_ms = stamp;
            end
        end else begin
            // a dropped expiry lets the late-timeout races happen on the next edge
            if (timer_live && $urandom_range(0, 99) < 10) timer_live = 1'b0;
            if (timer_live && (timer_at - now_ms) <= (edge_at - now_ms)) begin
                cmd  = EV_TIMER;
                late = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 50) : 0;
                if (late > edge_at - timer_at) late = 0;
                stamp  = timer_at + late;
                now_ms = stamp;
            end else begin
                cmd            = button_pressed ? EV_UP : EV_DOWN;
                stamp          = edge_at;
                now_ms         = stamp;
                button_pressed = !button_pressed;
                edge_at        = now_ms + (button_pressed ? hold_length() : gap_length());
            end
        end
        send_event(cmd, stamp, arm_ms);
        timer_live = (arm_ms != '0);
        timer_at   = stamp + TIME_W'(arm_ms);
    endtask

    // Hand-picked sequence at the reset settings (450 / 1500 / 10000 / 30).
    task automatic directed_events();
        logic [ARM_W-1:0]  unused;
        logic [TIME_W-1:0] base;
        base = 32'hFFFF_FF00;
        // idle: anything but a press cancels, including the spare code
        send_event(EV_UP,    32'd0,          unused);
        send_event(EV_SPARE, 32'hFFFF_FFFF,  unused);
        // ghost pulse with ignored events in between
        send_event(EV_DOWN,  32'd1000,       unused);
        send_event(EV_SPARE, 32'd1005,       unused);
        send_event(EV_DOWN,  32'd1006,       unused);
        send_event(EV_UP,    32'd1010,       unused);
        // single press closed by the window timer
        send_event(EV_DOWN,  32'd2000,       unused);
        send_event(EV_UP,    32'd2100,       unused);
        send_event(EV_UP,    32'd2200,       unused);
        send_event(EV_TIMER, 32'd2550,       unused);
        // double press with a ghost on the second: window keeps its first end
        send_event(EV_DOWN,  32'd3000,       unused);
        send_event(EV_UP,    32'd3100,       unused);
        send_event(EV_DOWN,  32'd3200,       unused);
        send_event(EV_UP,    32'd3210,       unused);
        send_event(EV_DOWN,  32'd3300,       unused);
        send_event(EV_UP,    32'd3400,       unused);
        // second press after the window lapsed unseen, then a long release
        // with no timeout in between
        send_event(EV_DOWN,  32'd4000,       unused);
        send_event(EV_UP,    32'd4100,       unused);
        send_event(EV_DOWN,  32'd4700,       unused);
        send_event(EV_UP,    32'd6300,       unused);
        // held across the wrap: deadline met exactly, then passed, then reboot
        send_event(EV_DOWN,  base,           unused);
        send_event(EV_TIMER, base + 1500,    unused);
        send_event(EV_SPARE, base + 10000,   unused);
        send_event(EV_DOWN,  base + 20000,   unused);
        send_event(EV_TIMER, base + 20001,   unused);
    endtask

    initial begin
        logic [CFG_W-1:0] window;
        logic [CFG_W-1:0] long_hold;
        logic [CFG_W-1:0] reboot;
        logic [CFG_W-1:0] debounce;

        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= REG_DOUBLE_WINDOW;
        i_cfg_data           <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.cmd           <= EV_DOWN;
        req_ch.event_time_ms <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_events();
        wait_drained();

        button_pressed = 1'b0;
        now_ms         = 32'hFFFE_0000;
        edge_at        = now_ms + 100;
        timer_live     = 1'b0;
        timer_at       = '0;

        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            // receiver-heavy idling first, then sender-heavy, then none at all
            case (phase / 2)
                0:       begin send_idle_pct = 28; recv_idle_pct = 71; end
                1:       begin send_idle_pct = 71; recv_idle_pct = 28; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            case (phase)
                0: begin window = '0; long_hold = '0; reboot = '0; debounce = '0; end
                1: begin window = '1; long_hold = '1; reboot = '1; debounce = '1; end
                2: begin window = 300; long_hold = 1000; reboot = 4000; debounce = 25; end
                3: begin
                    window    = CFG_W'($urandom_range(0, 65535));
                    long_hold = CFG_W'($urandom_range(0, 65535));
                    reboot    = CFG_W'($urandom_range(0, 65535));
                    debounce  = CFG_W'($urandom_range(0, 65535));
                end
                4: begin
                    window    = CFG_W'($urandom_range(1, 600));
                    long_hold = CFG_W'($urandom_range(1, 2000));
                    reboot    = CFG_W'($urandom_range(1, 8000));
                    debounce  = CFG_W'($urandom_range(1, 60));
                end
                default: begin
                    window    = RST_DOUBLE_WINDOW;
                    long_hold = RST_LONG_PRESS;
                    reboot    = RST_REBOOT_PRESS;
                    debounce  = RST_DEBOUNCE;
                end
            endcase
            wait_drained();
            apply_settings(window, long_hold, reboot, debounce);
            for (int unsigned n = 0; n < PHASE_EVENTS; n++) begin
                // result side stalls for a long stretch so the block backs up
                if (phase == 1 && n == 40) hold_results = 1'b1;
                // sender goes quiet until every outcome is back
                if (phase == 3 && n == 40) wait_drained();
                gesture_step();
            end
        end

        wait_drained();
        repeat (5) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
